FILE: rtl/core/assert_macros.svh
// assertion macros shared by the scheduler rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is applied
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

FILE: rtl/core/rrts_pkg.sv
// types and codes of the round-robin task scheduler
// no dependencies; imported by round_robin_task_scheduler_core
package rrts_pkg;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PASS,
		S_FIN
	} sched_state_t;

	typedef logic [1:0] task_st_t;

	localparam task_st_t TS_READY   = 2'd0;
	localparam task_st_t TS_RUNNING = 2'd1;
	localparam task_st_t TS_TIMED   = 2'd2;
	localparam task_st_t TS_MUTEX   = 2'd3;

	typedef logic [2:0] opcode_t;

	localparam opcode_t OP_TICK     = 3'd0;
	localparam opcode_t OP_SLEEP    = 3'd1;
	localparam opcode_t OP_YIELD    = 3'd2;
	localparam opcode_t OP_LOCK     = 3'd3;
	localparam opcode_t OP_UNLOCK   = 3'd4;
	localparam opcode_t OP_REGISTER = 3'd5;

endpackage

FILE: rtl/core/round_robin_task_scheduler_core.sv
// round-robin task scheduler with idle task, timed sleep and one mutex
// depends on rrts_pkg and assert_macros.svh
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_ready  | opcode, sleep_ticks, signal_value
//  out     | out_valid/out_ready| running_task, tick_restart, status
//
// tick, sleep, yield and a blocked lock reschedule: the result follows the
// wake-and-scan pass, which reads one entry of the task memories per cycle
// (no pass with no task registered); other opcodes give their result at
// acceptance.
// one item at a time; the next is taken once the result register is free.
// no clearing pass after reset: every entry read has been written first.
// a stalled output holds the result and the block waits for it.
`include "assert_macros.svh"

module round_robin_task_scheduler_core #(
	parameter int TASK_SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rrts_pkg::opcode_t opcode,
	input  logic [31:0]       sleep_ticks,
	input  logic [7:0]        signal_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        running_task,
	output logic              tick_restart,
	output logic              status
);
	import rrts_pkg::*;

	localparam int IW = $clog2(TASK_SLOTS);
	localparam logic [IW:0] SLOTS_W = (IW + 1)'(TASK_SLOTS);

	typedef logic [IW-1:0] idx_t;

	// task memories
	task_st_t    status_mem [TASK_SLOTS];
	logic [31:0] wake_mem   [TASK_SLOTS];

	sched_state_t state_q, state_d;
	idx_t         cur_q, cur_d;
	idx_t         count_q, count_d;
	logic [31:0]  tick_q, tick_d;
	logic         mutex_q, mutex_d;

	idx_t rd_idx_q, rd_idx_d;
	logic done_q, done_d;
	logic rd_en;
	logic v_s1;
	idx_t idx_s1;
	task_st_t st_s1;
	logic [31:0] wk_s1;

	logic aft_vld_q, aft_vld_d, bef_vld_q, bef_vld_d;
	idx_t aft_idx_q, aft_idx_d, bef_idx_q, bef_idx_d;

	logic out_valid_q;
	logic [3:0] run_q;
	logic restart_q, status_q;

	logic        st_we, wk_we;
	idx_t        st_wa, wk_wa;
	task_st_t    st_wd;
	logic [31:0] wk_wd;

	logic        accept, resched, load_out, out_rs_d, out_status_d, found;
	idx_t        out_run_d, chosen;
	logic [IW:0] cnt_inc;
	logic [IW+3:0] run_ext;
	task_st_t    st_new;
	logic        mutex_grab;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign rd_en    = (state_q == S_PASS) && !done_q;
	assign cnt_inc  = {1'b0, count_q} + 1'b1;

	// first ready after the current task, else first ready before it
	assign found  = aft_vld_q || bef_vld_q;
	assign chosen = aft_vld_q ? aft_idx_q : (bef_vld_q ? bef_idx_q : '0);

	// wake evaluation of the entry read last cycle
	always_comb begin
		st_new     = st_s1;
		mutex_grab = 1'b0;
		if (st_s1 == TS_TIMED && $signed(tick_q) > $signed(wk_s1)) begin
			st_new = TS_READY;
		end
		if (st_new == TS_MUTEX && !mutex_q) begin
			st_new     = TS_READY;
			mutex_grab = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			count_q     <= '0;
			tick_q      <= '0;
			mutex_q     <= 1'b0;
			rd_idx_q    <= '0;
			done_q      <= 1'b1;
			v_s1        <= 1'b0;
			aft_vld_q   <= 1'b0;
			bef_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_q     <= cur_d;
			count_q   <= count_d;
			tick_q    <= tick_d;
			mutex_q   <= mutex_d;
			rd_idx_q  <= rd_idx_d;
			done_q    <= done_d;
			v_s1      <= rd_en;
			aft_vld_q <= aft_vld_d;
			bef_vld_q <= bef_vld_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		aft_idx_q <= aft_idx_d;
		bef_idx_q <= bef_idx_d;
		idx_s1    <= rd_idx_q;
		if (load_out) begin
			run_q     <= run_ext[3:0];
			restart_q <= out_rs_d;
			status_q  <= out_status_d;
		end
	end

	// memories: one write port each, registered read
	always_ff @(posedge clk) begin
		if (st_we) begin
			status_mem[st_wa] <= st_wd;
		end
		if (wk_we) begin
			wake_mem[wk_wa] <= wk_wd;
		end
		if (rd_en) begin
			st_s1 <= status_mem[rd_idx_q];
			wk_s1 <= wake_mem[rd_idx_q];
		end
	end

	always_comb begin
		state_d      = state_q;
		cur_d        = cur_q;
		count_d      = count_q;
		tick_d       = tick_q;
		mutex_d      = mutex_q;
		rd_idx_d     = rd_idx_q;
		done_d       = done_q;
		aft_vld_d    = aft_vld_q;
		aft_idx_d    = aft_idx_q;
		bef_vld_d    = bef_vld_q;
		bef_idx_d    = bef_idx_q;
		st_we        = 1'b0;
		st_wa        = cur_q;
		st_wd        = TS_READY;
		wk_we        = 1'b0;
		wk_wa        = cur_q;
		wk_wd        = '0;
		load_out     = 1'b0;
		out_run_d    = cur_q;
		out_rs_d     = 1'b0;
		out_status_d = 1'b0;
		resched      = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_TICK: begin
							tick_d = tick_q + 1'b1;
							st_we  = 1'b1;
							if (signal_value != '0) begin
								// waits on a signal: timed-blocked with wake time zero
								st_wd = TS_TIMED;
								wk_we = 1'b1;
								wk_wd = '0;
							end
							resched = 1'b1;
						end
						OP_SLEEP: begin
							st_we   = 1'b1;
							st_wd   = TS_TIMED;
							wk_we   = 1'b1;
							wk_wd   = tick_q + sleep_ticks;
							resched = 1'b1;
						end
						OP_YIELD: begin
							st_we   = 1'b1;
							resched = 1'b1;
						end
						OP_LOCK: begin
							if (!mutex_q) begin
								mutex_d  = 1'b1;
								load_out = 1'b1;
							end else begin
								st_we   = 1'b1;
								st_wd   = TS_MUTEX;
								resched = 1'b1;
							end
						end
						OP_UNLOCK: begin
							mutex_d  = 1'b0;
							load_out = 1'b1;
						end
						OP_REGISTER: begin
							load_out = 1'b1;
							if (cnt_inc >= SLOTS_W) begin
								out_status_d = 1'b1;
							end else begin
								st_we   = 1'b1;
								st_wa   = cnt_inc[IW-1:0];
								st_wd   = TS_READY;
								count_d = cnt_inc[IW-1:0];
							end
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
					if (resched) begin
						aft_vld_d = 1'b0;
						bef_vld_d = 1'b0;
						rd_idx_d  = idx_t'(1);
						done_d    = 1'b0;
						// no registered task: skip the pass, straight to S_FIN
						state_d   = (count_q == '0) ? S_FIN : S_PASS;
					end
				end
			end
			S_PASS: begin
				if (rd_en) begin
					rd_idx_d = idx_t'(rd_idx_q + 1'b1);
					done_d   = (rd_idx_q == count_q);
				end
				if (v_s1) begin
					st_we = 1'b1;
					st_wa = idx_s1;
					st_wd = st_new;
					if (mutex_grab) begin
						mutex_d = 1'b1;
					end
					if (st_new == TS_READY) begin
						if (idx_s1 > cur_q && !aft_vld_q) begin
							aft_vld_d = 1'b1;
							aft_idx_d = idx_s1;
						end else if (idx_s1 < cur_q && !bef_vld_q) begin
							bef_vld_d = 1'b1;
							bef_idx_d = idx_s1;
						end
					end
				end
				// last entry is written back in the cycle done is seen
				if (done_q) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					st_we     = 1'b1;
					st_wa     = chosen;
					st_wd     = TS_RUNNING;
					cur_d     = chosen;
					load_out  = 1'b1;
					out_run_d = chosen;
					out_rs_d  = found;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign run_ext      = {4'b0000, out_run_d};
	assign out_valid    = out_valid_q;
	assign running_task = run_q;
	assign tick_restart = restart_q;
	assign status       = status_q;

	`ASSERT_NEVER(a_cur_registered, cur_q > count_q, "current task beyond registered tasks")
	`ASSERT_CLK(a_pass_range, rd_en |-> (rd_idx_q != '0 && rd_idx_q <= count_q), "bad pass read")
	`ASSERT_CLK(a_no_reselect, (state_q == S_FIN && found) |-> (chosen != cur_q), "reselected")
	`ASSERT_CLK(a_yield_scans, (accept && opcode == OP_YIELD) |=> (state_q != S_IDLE), "no pass")

endmodule
